// File: rtl/rpom_pkg.sv
// Shared constants, controller states and command/status types for the page owner map.
`default_nettype none

package rpom_pkg;

  localparam int FIELD_W          = 48;
  localparam int PAGE_OFS         = 12;
  localparam int IN_DATA_W        = 96;
  localparam int DEF_LEVELS       = 3;
  localparam int DEF_INDEX_BITS   = 12;
  localparam int DEF_NODE_POOL    = 16;
  localparam int DEF_DESCR_BITS   = 48;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EVAL,
    ST_ALLOC,
    ST_DONE
  } rpom_state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd;
    logic step;
    logic alloc_wr;
    logic leaf_wr;
    logic res_hit;
    logic res_miss;
    logic res_refuse;
    logic out_load;
  } rpom_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_insert;
    logic last_level;
    logic pre_last;
    logic child_hit;
    logic pool_ok;
    logic out_free;
  } rpom_sts_t;

endpackage

`default_nettype wire

// File: rtl/rpom_ctrl.sv
// Controller state machine: sequences store clear, tree walk, allocation and result handoff.
`default_nettype none

module rpom_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  rpom_pkg::rpom_sts_t sts,
  output rpom_pkg::rpom_cmd_t cmd
);
  import rpom_pkg::*;

  rpom_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.last_level && sts.is_insert) state_nxt = ST_DONE;
        else state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.last_level) state_nxt = ST_DONE;
        else if (sts.child_hit) state_nxt = ST_WALK;
        else if (sts.is_insert && sts.pool_ok) state_nxt = ST_ALLOC;
        else state_nxt = ST_DONE;
      end
      ST_ALLOC: begin
        // once the last internal level has its child, go write the leaf
        if (sts.pre_last) state_nxt = ST_WALK;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_WALK: begin
        if (sts.last_level && sts.is_insert) begin
          cmd.leaf_wr  = 1'b1;
          cmd.res_miss = 1'b1;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      ST_EVAL: begin
        if (sts.last_level) begin
          cmd.res_hit = 1'b1;
        end else if (sts.child_hit) begin
          cmd.step = 1'b1;
        end else if (sts.is_insert && !sts.pool_ok) begin
          cmd.res_refuse = 1'b1;
        end else if (!sts.is_insert) begin
          cmd.res_miss = 1'b1;
        end
      end
      ST_ALLOC: cmd.alloc_wr = 1'b1;
      ST_DONE:  cmd.out_load = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rpom_dp.sv
// Datapath: node store memory, walk registers, pool counter and output register.
`default_nettype none

module rpom_dp #(
  parameter int LEVELS          = rpom_pkg::DEF_LEVELS,
  parameter int INDEX_BITS      = rpom_pkg::DEF_INDEX_BITS,
  parameter int NODE_POOL       = rpom_pkg::DEF_NODE_POOL,
  parameter int DESCRIPTOR_BITS = rpom_pkg::DEF_DESCR_BITS
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  rpom_pkg::rpom_cmd_t               cmd,
  output rpom_pkg::rpom_sts_t               sts,
  input  wire  [rpom_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire  [0:0]                        in_tuser,
  input  wire                               out_tready,
  output logic                              out_tvalid,
  output logic [rpom_pkg::FIELD_W-1:0]      out_tdata,
  output logic [0:0]                        out_tuser
);
  import rpom_pkg::*;

  localparam int NODE_BITS = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int NIU_W     = $clog2(NODE_POOL + 1);
  localparam int CNT_W     = NIU_W + 3;
  localparam int OWN_W     = (DESCRIPTOR_BITS < FIELD_W) ? DESCRIPTOR_BITS : FIELD_W;
  localparam int STORE_W   = (OWN_W > NIU_W) ? OWN_W : NIU_W;
  localparam int AW        = NODE_BITS + INDEX_BITS;
  localparam int DEPTH     = NODE_POOL << INDEX_BITS;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PN_W      = LEVELS * INDEX_BITS;
  localparam int EXT_W     = PN_W + FIELD_W;

  logic [STORE_W-1:0] mem [DEPTH];
  logic [STORE_W-1:0] mem_rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [STORE_W-1:0] mem_wdata;

  logic [AW-1:0]        clr_cnt_r;
  logic                 op_r;
  logic [PN_W-1:0]      pn_r;
  logic [OWN_W-1:0]     owner_r;
  logic [NODE_BITS-1:0] node_r;
  logic [LVL_W-1:0]     level_r;
  logic [NIU_W-1:0]     niu_r;
  logic [FIELD_W-1:0]   res_owner_r;
  logic                 res_status_r;
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_owner_r;
  logic                 out_status_r;

  logic [EXT_W-1:0]     addr_ext;
  logic [CNT_W-1:0]     pool_need;

  // page number: drop the offset, zero-extend past the 48-bit address
  assign addr_ext  = EXT_W'(in_tdata[FIELD_W-1:0]);
  assign pool_need = CNT_W'(niu_r) + CNT_W'(LEVELS - 1) - CNT_W'(level_r);

  always_comb begin
    mem_we    = cmd.clr_wr | cmd.alloc_wr | cmd.leaf_wr;
    mem_addr  = cmd.clr_wr ? clr_cnt_r : {node_r, pn_r[INDEX_BITS-1:0]};
    mem_wdata = '0;
    if (cmd.alloc_wr) mem_wdata = STORE_W'(niu_r);
    else if (cmd.leaf_wr) mem_wdata = STORE_W'(owner_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.rd) mem_rdata_r <= mem[mem_addr];
  end

  always_comb begin
    sts.clr_done   = (clr_cnt_r == AW'(DEPTH - 1));
    sts.is_insert  = op_r;
    sts.last_level = (level_r == LVL_W'(LEVELS - 1));
    sts.pre_last   = (level_r == LVL_W'(LEVELS - 2));
    sts.child_hit  = (mem_rdata_r != '0) && (mem_rdata_r < STORE_W'(NODE_POOL));
    sts.pool_ok    = (pool_need <= CNT_W'(NODE_POOL));
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      niu_r       <= NIU_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.alloc_wr) niu_r <= niu_r + NIU_W'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser[0];
      pn_r    <= addr_ext[PAGE_OFS +: PN_W];
      owner_r <= in_tdata[FIELD_W +: OWN_W];
      node_r  <= '0;
      level_r <= '0;
    end else if (cmd.step) begin
      node_r  <= mem_rdata_r[NODE_BITS-1:0];
      level_r <= level_r + LVL_W'(1);
      pn_r    <= pn_r >> INDEX_BITS;
    end else if (cmd.alloc_wr) begin
      node_r  <= niu_r[NODE_BITS-1:0];
      level_r <= level_r + LVL_W'(1);
      pn_r    <= pn_r >> INDEX_BITS;
    end
    if (cmd.res_hit) begin
      res_owner_r  <= FIELD_W'(mem_rdata_r[OWN_W-1:0]);
      res_status_r <= 1'b0;
    end else if (cmd.res_miss) begin
      res_owner_r  <= '0;
      res_status_r <= 1'b0;
    end else if (cmd.res_refuse) begin
      res_owner_r  <= '0;
      res_status_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_owner_r  <= res_owner_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_owner_r;
  assign out_tuser[0] = out_status_r;

endmodule

`default_nettype wire

// File: rtl/radix_page_owner_map.sv
// Top level of the radix page owner map: controller plus datapath.
//
// Sparse map from 48-bit addresses to owner descriptors, kept as a radix
// tree of LEVELS levels in one node store of NODE_POOL << INDEX_BITS words.
// Input channel (in_*): one request per handshake; in_tuser selects lookup
// (0) or insert (1), in_tdata carries the address and the descriptor.
// Result channel (out_*): one result per request, in order; out_tdata is the
// descriptor found (0 if absent, always 0 for insert), out_tuser flags an
// insert refused because the node pool is exhausted.
// Requests are processed one at a time. Each tree level is one read (ST_WALK)
// and one evaluate (ST_EVAL) on the single-port store; an insert allocates
// each missing node (ST_ALLOC) before it writes the leaf, or is refused
// with no write when the pool cannot cover every missing node. After reset
// the store is cleared one word per cycle with in_tready low. The root node
// is present. The result sits in an output register; a new request is
// accepted while it waits, and the block holds its next result until
// out_tready frees it.
`default_nettype none

module radix_page_owner_map #(
  parameter int LEVELS          = rpom_pkg::DEF_LEVELS,
  parameter int INDEX_BITS      = rpom_pkg::DEF_INDEX_BITS,
  parameter int NODE_POOL       = rpom_pkg::DEF_NODE_POOL,
  parameter int DESCRIPTOR_BITS = rpom_pkg::DEF_DESCR_BITS
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [rpom_pkg::IN_DATA_W-1:0]  in_tdata,   // [47:0] address, [95:48] owner_in
  input  wire  [0:0]                      in_tuser,   // [0] operation
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [rpom_pkg::FIELD_W-1:0]    out_tdata,  // [47:0] owner_out
  output logic [0:0]                      out_tuser   // [0] status
);
  import rpom_pkg::*;

  rpom_cmd_t cmd;
  rpom_sts_t sts;

  rpom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpom_dp #(
    .LEVELS          (LEVELS),
    .INDEX_BITS      (INDEX_BITS),
    .NODE_POOL       (NODE_POOL),
    .DESCRIPTOR_BITS (DESCRIPTOR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // refused insert never reports a descriptor
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("refused insert with nonzero descriptor");

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  // result register only loaded when it is free
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result overwritten before delivery");

  // store clear and request intake never overlap
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_tready)
    else $error("request accepted during store clear");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the radix page owner map: directed, random and pool exhaustion runs.
module tb;
  import rpom_pkg::*;

  localparam int LEVELS       = DEF_LEVELS;
  localparam int INDEX_BITS   = DEF_INDEX_BITS;
  localparam int NODE_POOL    = DEF_NODE_POOL;
  localparam int NODE_ENTRIES = 1 << INDEX_BITS;
  localparam int STALL_LIMIT  = 200000;  // covers the store clear after reset

  localparam logic OP_LOOKUP      = 1'b0;
  localparam logic OP_INSERT      = 1'b1;
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] owner;
    logic               status;
  } owner_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [FIELD_W-1:0]   out_tdata;
  logic [0:0]           out_tuser;

  // shadow copy of the tree
  bit [FIELD_W-1:0] tree_words [NODE_POOL*NODE_ENTRIES];
  int unsigned      nodes_taken = 1;

  owner_result_t owner_results_due [$];
  int            errors = 0;
  int            quiet_cycles = 0;
  int            ready_hold = 0;
  bit            steady_flow = 1'b0;

  radix_page_owner_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic int tree_index(logic [FIELD_W-1:0] addr, int lvl);
    return int'((addr >> (PAGE_OFS + lvl * INDEX_BITS)) & (NODE_ENTRIES - 1));
  endfunction

  function automatic int child_node(int node, int idx);
    bit [FIELD_W-1:0] v;
    v = tree_words[node * NODE_ENTRIES + idx];
    if (v == 0 || v >= NODE_POOL) return 0;
    return int'(v);
  endfunction

  // Walks the shadow tree for one request and updates it as the block would.
  function automatic owner_result_t map_request(logic op, logic [FIELD_W-1:0] addr,
                                                logic [FIELD_W-1:0] owner);
    owner_result_t r;
    int node;
    int nxt;
    int idx;
    int need;
    r = '{owner: '0, status: STATUS_DONE};
    node = 0;
    if (op == OP_LOOKUP) begin
      for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
        node = child_node(node, tree_index(addr, lvl));
        if (node == 0) return r;
      end
      r.owner = tree_words[node * NODE_ENTRIES + tree_index(addr, LEVELS - 1)];
      return r;
    end
    // refuse as a whole if the pool can't cover every missing node
    need = 0;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      nxt = child_node(node, tree_index(addr, lvl));
      if (nxt == 0) begin
        need = LEVELS - 1 - lvl;
        break;
      end
      node = nxt;
    end
    if (nodes_taken + need > NODE_POOL) begin
      r.status = STATUS_REFUSED;
      return r;
    end
    node = 0;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      idx = tree_index(addr, lvl);
      nxt = child_node(node, idx);
      if (nxt == 0) begin
        nxt = nodes_taken;
        nodes_taken++;
        tree_words[node * NODE_ENTRIES + idx] = FIELD_W'(nxt);
      end
      node = nxt;
    end
    tree_words[node * NODE_ENTRIES + tree_index(addr, LEVELS - 1)] = owner;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] page_addr(logic [11:0] leaf_idx, logic [11:0] mid_idx,
                                                   logic [11:0] root_idx, logic [11:0] ofs);
    return {leaf_idx, mid_idx, root_idx, ofs};
  endfunction

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send_request(input logic op, input logic [FIELD_W-1:0] addr,
                              input logic [FIELD_W-1:0] owner);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {owner, addr};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    owner_results_due.push_back(map_request(op, addr, owner));
  endtask

  // result checker
  always @(posedge clk) begin
    owner_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owner_results_due.size() == 0) begin
        report_mismatch("result with no request pending", out_tdata, '0);
      end else begin
        want = owner_results_due.pop_front();
        if (out_tdata !== want.owner) report_mismatch("owner_out", out_tdata, want.owner);
        if (out_tuser[0] !== want.status)
          report_mismatch("status", FIELD_W'(out_tuser[0]), FIELD_W'(want.status));
      end
    end
  end

  // result side backpressure in short bursts
  always @(posedge clk) begin
    if (!rst_n || steady_flow) begin
      out_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 4) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed_basics();
    send_request(OP_LOOKUP, '0, '0);                       // empty map
    send_request(OP_LOOKUP, '1, '1);
    send_request(OP_INSERT, '0, '1);
    send_request(OP_LOOKUP, 48'h0000_0000_0FFF, '0);       // offset bits ignored
    send_request(OP_INSERT, '1, 48'h1);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_INSERT, '0, 48'h5A5A_A5A5_0F0F);       // overwrite
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_INSERT, page_addr(12'h0, 12'h0, 12'h1, 12'h0), '0);  // zero owner
    send_request(OP_LOOKUP, page_addr(12'h0, 12'h0, 12'h1, 12'hABC), '0);
    send_request(OP_LOOKUP, page_addr(12'h5, 12'h0, 12'h0, 12'h0), '0);  // empty leaf slot
    send_request(OP_LOOKUP, page_addr(12'h0, 12'h7, 12'h0, 12'h0), '0);  // missing mid node
  endtask

  function automatic logic [11:0] hot_index();
    case ($urandom_range(0, 3))
      0:       return 12'h000;
      1:       return 12'h001;
      2:       return 12'h800;
      default: return 12'hFFF;
    endcase
  endfunction

  // Mostly addresses on a few hot paths so lookups hit and the pool fills;
  // the rest fully random.
  task automatic test_random_traffic(input int count);
    logic               op;
    logic [11:0]        leaf_idx;
    logic [FIELD_W-1:0] addr;
    logic [FIELD_W-1:0] owner;
    for (int n = 0; n < count; n++) begin
      op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       owner = '0;
        1:       owner = '1;
        default: owner = FIELD_W'({$urandom, $urandom});
      endcase
      if ($urandom_range(0, 4) == 0) begin
        addr = FIELD_W'({$urandom, $urandom});
      end else begin
        leaf_idx = ($urandom_range(0, 5) == 0) ? 12'hFFF - 12'($urandom_range(0, 3))
                                               : 12'($urandom_range(0, 7));
        addr = page_addr(leaf_idx, hot_index(), hot_index(), 12'($urandom));
      end
      send_request(op, addr, owner);
    end
  endtask

  task automatic test_pool_exhaustion();
    int k;
    k = 0;
    while (nodes_taken + 2 <= NODE_POOL) begin
      send_request(OP_INSERT, page_addr(12'h0, 12'h0, 12'hF00 + 12'(k), 12'h0),
                   FIELD_W'({$urandom, $urandom}));
      k++;
    end
    if (nodes_taken + 1 <= NODE_POOL)
      send_request(OP_INSERT, page_addr(12'h0, 12'hEE0, 12'h0, 12'h0), 48'hC0FF_EE00_0001);
    // pool is full now: a fresh path and a half-built one are both refused
    send_request(OP_INSERT, page_addr(12'h0, 12'h0, 12'hF80, 12'h0), 48'h1234_5678_9ABC);
    send_request(OP_INSERT, page_addr(12'h0, 12'hEE1, 12'h0, 12'h0), 48'h1234_5678_9ABC);
    send_request(OP_LOOKUP, page_addr(12'h0, 12'h0, 12'hF80, 12'h0), '0);
    send_request(OP_LOOKUP, page_addr(12'h0, 12'hEE1, 12'h0, 12'h0), '0);
    // a path that already exists still takes inserts
    send_request(OP_INSERT, page_addr(12'h3, 12'h0, 12'h0, 12'h0), 48'hFEED_0000_BEEF);
    send_request(OP_LOOKUP, page_addr(12'h3, 12'h0, 12'h0, 12'h0), '0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_random_traffic(500);
    test_pool_exhaustion();
    steady_flow = 1'b1;
    test_random_traffic(320);
    in_tvalid <= 1'b0;
    while (owner_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
